>>> rtl/cpu_opcode_row_1x_execute_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the row 1x execute unit
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef CPU_OPCODE_ROW_1X_EXECUTE_UNIT_MACROS_SVH
`define CPU_OPCODE_ROW_1X_EXECUTE_UNIT_MACROS_SVH

// Checked only while out of reset.
`define CPUROW_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CPUROW_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/cpurow_pkg.sv
// ----------------------------------------------------------------------------
// cpurow_pkg
// Types and constants for the row 1x opcode execute unit.
// ----------------------------------------------------------------------------
package cpurow_pkg;

  typedef enum logic [3:0] {
    OP_STOP      = 4'h0,
    OP_LD_DE_D16 = 4'h1,
    OP_LD_MDE_A  = 4'h2,
    OP_INC_DE    = 4'h3,
    OP_INC_D     = 4'h4,
    OP_DEC_D     = 4'h5,
    OP_LD_D_D8   = 4'h6,
    OP_RLA       = 4'h7,
    OP_JR        = 4'h8,
    OP_ADD_HL_DE = 4'h9,
    OP_LD_A_MDE  = 4'hA,
    OP_DEC_DE    = 4'hB,
    OP_INC_E     = 4'hC,
    OP_DEC_E     = 4'hD,
    OP_LD_E_D8   = 4'hE,
    OP_RRA       = 4'hF
  } op_e;

  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  localparam logic [3:0] CYC_4  = 4'd4;
  localparam logic [3:0] CYC_8  = 4'd8;
  localparam logic [3:0] CYC_12 = 4'd12;

  localparam logic [1:0] LEN_1 = 2'd1;
  localparam logic [1:0] LEN_2 = 2'd2;
  localparam logic [1:0] LEN_3 = 2'd3;

  typedef struct packed {
    logic [4:0]  command;
    logic [15:0] immediate;
    logic [7:0]  load_data;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  a_out;
    logic [7:0]  d_out;
    logic [7:0]  e_out;
    logic [15:0] hl_out;
    logic [15:0] pc_out;
    logic [3:0]  flags_out;
    logic        stopped;
    logic        mem_write;
    logic [15:0] mem_address;
    logic [7:0]  mem_data;
    logic [3:0]  cycles;
  } res_t;

endpackage

>>> rtl/cpurow_core.sv
// ----------------------------------------------------------------------------
// cpurow_core
// Architectural registers and combinational execute of one row 1x opcode.
// ----------------------------------------------------------------------------
module cpurow_core
  import cpurow_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic exec_i,
  input  cmd_t cmd_i,
  output res_t res_o
);

  logic [7:0]  a_q, a_d, d_q, d_d, e_q, e_d;
  logic [15:0] hl_q, hl_d, pc_q, pc_d;
  logic [3:0]  flags_q, flags_d;
  logic        stop_q, stop_d;

  op_e         op;
  logic [15:0] de, de_new, pc_off;
  logic [1:0]  len;
  logic [3:0]  cyc;
  logic        wr;
  logic [7:0]  imm8, inc_v, inc_r, dec_v, dec_r;
  logic [16:0] hl_sum;
  logic [12:0] hl_half;
  logic        use_d;

  always_comb begin
    op      = op_e'(cmd_i.command[3:0]);
    imm8    = cmd_i.immediate[7:0];
    de      = {d_q, e_q};
    use_d   = (op == OP_INC_D) || (op == OP_DEC_D);
    inc_v   = use_d ? d_q : e_q;
    dec_v   = inc_v;
    inc_r   = inc_v + 8'd1;
    dec_r   = dec_v - 8'd1;
    hl_sum  = {1'b0, hl_q} + {1'b0, de};
    hl_half = {1'b0, hl_q[11:0]} + {1'b0, de[11:0]};

    a_d     = a_q;
    d_d     = d_q;
    e_d     = e_q;
    hl_d    = hl_q;
    flags_d = flags_q;
    stop_d  = stop_q;
    de_new  = de;
    pc_off  = 16'd0;
    len     = LEN_1;
    cyc     = CYC_4;
    wr      = 1'b0;

    unique case (op)
      OP_STOP: begin
        stop_d = 1'b1;
        len    = LEN_2;
      end
      OP_LD_DE_D16: begin
        de_new = cmd_i.immediate;
        len    = LEN_3;
        cyc    = CYC_12;
      end
      OP_LD_MDE_A: begin
        wr  = 1'b1;
        cyc = CYC_8;
      end
      OP_INC_DE: begin
        de_new = de + 16'd1;
        cyc    = CYC_8;
      end
      OP_DEC_DE: begin
        de_new = de - 16'd1;
        cyc    = CYC_8;
      end
      OP_INC_D, OP_INC_E: begin
        if (use_d) begin
          de_new[15:8] = inc_r;
        end else begin
          de_new[7:0] = inc_r;
        end
        flags_d = {inc_r == 8'd0, 1'b0, inc_v[3:0] == 4'hF, flags_q[FLAG_C]};
      end
      OP_DEC_D, OP_DEC_E: begin
        if (use_d) begin
          de_new[15:8] = dec_r;
        end else begin
          de_new[7:0] = dec_r;
        end
        flags_d = {dec_r == 8'd0, 1'b1, dec_v[3:0] == 4'h0, flags_q[FLAG_C]};
      end
      OP_LD_D_D8: begin
        de_new[15:8] = imm8;
        len          = LEN_2;
        cyc          = CYC_8;
      end
      OP_LD_E_D8: begin
        de_new[7:0] = imm8;
        len         = LEN_2;
        cyc         = CYC_8;
      end
      OP_RLA: begin
        flags_d = {3'b000, a_q[7]};
        a_d     = {a_q[6:0], flags_q[FLAG_C]};
      end
      OP_RRA: begin
        flags_d = {3'b000, a_q[0]};
        a_d     = {flags_q[FLAG_C], a_q[7:1]};
      end
      OP_JR: begin
        pc_off = {{8{imm8[7]}}, imm8};
        len    = LEN_2;
        cyc    = CYC_12;
      end
      OP_ADD_HL_DE: begin
        hl_d    = hl_sum[15:0];
        flags_d = {flags_q[FLAG_Z], 1'b0, hl_half[12], hl_sum[16]};
        cyc     = CYC_8;
      end
      OP_LD_A_MDE: begin
        a_d = cmd_i.load_data;
        cyc = CYC_8;
      end
    endcase

    d_d  = de_new[15:8];
    e_d  = de_new[7:0];
    pc_d = pc_q + pc_off + {14'd0, len};

    res_o.a_out       = a_d;
    res_o.d_out       = d_d;
    res_o.e_out       = e_d;
    res_o.hl_out      = hl_d;
    res_o.pc_out      = pc_d;
    res_o.flags_out   = flags_d;
    res_o.stopped     = stop_d;
    res_o.mem_write   = wr;
    res_o.mem_address = wr ? de : 16'd0;
    res_o.mem_data    = wr ? a_q : 8'd0;
    res_o.cycles      = cyc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q     <= 8'd0;
      d_q     <= 8'd0;
      e_q     <= 8'd0;
      hl_q    <= 16'd0;
      pc_q    <= 16'd0;
      flags_q <= 4'd0;
      stop_q  <= 1'b0;
    end else if (exec_i) begin
      a_q     <= a_d;
      d_q     <= d_d;
      e_q     <= e_d;
      hl_q    <= hl_d;
      pc_q    <= pc_d;
      flags_q <= flags_d;
      stop_q  <= stop_d;
    end
  end

endmodule

>>> rtl/cpu_opcode_row_1x_execute_unit.sv
// ----------------------------------------------------------------------------
// cpu_opcode_row_1x_execute_unit
// Executes opcodes 0x10..0x1F against its own A, D, E, HL, PC, flags and
// stop mark, one instruction per transfer.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one instruction per
// transfer: opcode, immediate bytes and the byte read at DE.
// Output channel (out_valid_o / out_stall_i / out_data_o): one result per
// instruction with updated registers, optional memory write and cycle cost.
//
// The input register takes the instruction, then execute writes the result
// into the result register unless the receiver stalls it. Throughput: one
// instruction per cycle while the receiver does not stall; the register
// update is a single pass of short logic.
// Reset clears all registers, the stop mark and both pipeline stages.
// When the receiver stalls the result holds; the input register, if empty,
// still takes one more instruction, after which in_stall_o rises.
// ----------------------------------------------------------------------------
module cpu_opcode_row_1x_execute_unit
  import cpurow_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  cmd_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t out_data_o
);

  logic in_valid_q, in_valid_d;
  cmd_t in_q;
  logic out_valid_q, out_valid_d;
  res_t out_q, res;
  logic out_free, exec, in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign exec       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d  = in_take || (in_valid_q && !exec);
    out_valid_d = exec || (out_valid_q && out_stall_i);
  end

  cpurow_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .exec_i (exec),
    .cmd_i  (in_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q  <= '0;
      out_q <= '0;
    end else begin
      if (in_take) begin
        in_q <= in_data_i;
      end
      if (exec) begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/cpurow_checker.sv
// ----------------------------------------------------------------------------
// cpurow_checker
// Port-level checks on the row 1x execute unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "cpu_opcode_row_1x_execute_unit_macros.svh"

module cpurow_checker
  import cpurow_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input cmd_t in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input res_t out_data_o
);

  `CPUROW_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_valid_o, "result valid in reset")

  `CPUROW_ASSERT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")

  `CPUROW_ASSERT(a_in_hold, clk_i, rst_ni, in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i), "stalled input changed")

  `CPUROW_ASSERT(a_cycles, clk_i, rst_ni, out_valid_o |-> (out_data_o.cycles == CYC_4) || (out_data_o.cycles == CYC_8) || (out_data_o.cycles == CYC_12), "illegal cycle count")

  `CPUROW_ASSERT(a_nowrite, clk_i, rst_ni, out_valid_o && !out_data_o.mem_write |-> (out_data_o.mem_address == 16'd0) && (out_data_o.mem_data == 8'd0), "write fields set without write")

endmodule

bind cpu_opcode_row_1x_execute_unit cpurow_checker u_cpurow_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
